// ----- hdl/qph_pkg.sv -----
// Package for the quadratic-probe hash table: state encoding, status codes,
// register indexes and FNV-1a constants. No dependencies.
package qph_pkg;
   localparam logic [63:0] FNV_OFFSET = 64'hCBF29CE484222325;
   localparam logic [63:0] FNV_PRIME  = 64'h00000100000001B3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   localparam logic REG_TABLE_SLOTS = 1'b0;
   localparam logic REG_KEY_BYTES   = 1'b1;

   localparam int TS_WIDTH = 11;
   localparam int KB_WIDTH = 4;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_HASH_MUL, S_HASH_ACC, S_MOD, S_ADDR, S_READ,
      S_WAIT, S_CHECK, S_DONE
   } state_type;
endpackage

// ----- hdl/qph_hash.sv -----
// Iterative FNV-1a hash, one byte at a time; the 64x64 multiply is built from
// three 32x32 partial products (high-by-high falls above bit 63). Uses qph_pkg.
module qph_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] key,
   input  logic [3:0]  nbytes,
   output logic        done,
   output logic [63:0] hash
);
   import qph_pkg::*;

   logic [63:0] h_ff, h_in;
   logic [63:0] acc_ff, acc_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [1:0]  ph_ff, ph_in;
   logic        run_ff, run_in;
   logic [63:0] x;
   logic [31:0] a_op, b_op;
   logic [63:0] prod;
   logic [63:0] kshift;

   assign kshift = key >> {cnt_ff[2:0], 3'b000};
   assign x = h_ff ^ {56'd0, kshift[7:0]};
   always_comb begin
      unique case (ph_ff)
         2'd0: begin a_op = x[31:0];  b_op = FNV_PRIME[31:0];  end
         2'd1: begin a_op = x[31:0];  b_op = FNV_PRIME[63:32]; end
         2'd2: begin a_op = x[63:32]; b_op = FNV_PRIME[31:0];  end
         default: begin a_op = x[63:32]; b_op = FNV_PRIME[63:32]; end
      endcase
   end
   assign prod = a_op * b_op;

   always_comb begin
      h_in = h_ff; acc_in = acc_ff; cnt_in = cnt_ff; ph_in = ph_ff; run_in = run_ff;
      done = 1'b0;
      if (start) begin
         h_in = FNV_OFFSET; acc_in = '0; cnt_in = '0; ph_in = '0; run_in = 1'b1;
      end else if (run_ff) begin
         unique case (ph_ff)
            2'd0: acc_in = prod;
            2'd1: acc_in = acc_ff + {prod[31:0], 32'd0};
            2'd2: acc_in = acc_ff + {prod[31:0], 32'd0};
            default: acc_in = acc_ff;
         endcase
         ph_in = ph_ff + 2'd1;
         if (ph_ff == 2'd2) begin
            ph_in = 2'd0;
            h_in = acc_in;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff + 4'd1 >= nbytes) begin
               run_in = 1'b0;
               done = 1'b1;
            end
         end
      end
   end
   assign hash = acc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0; ph_ff <= '0; cnt_ff <= '0;
      end else begin
         run_ff <= run_in; ph_ff <= ph_in; cnt_ff <= cnt_in;
      end
      h_ff <= h_in; acc_ff <= acc_in;
   end
endmodule

// ----- hdl/qph_mod.sv -----
// Restoring bit-serial remainder of a 64-bit value by an 11-bit modulus,
// one bit per cycle. Uses qph_pkg.
module qph_mod (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [10:0] modulus,
   output logic        done,
   output logic [10:0] remainder
);
   import qph_pkg::*;

   logic [63:0] sh_ff, sh_in;
   logic [11:0] rem_ff, rem_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic [11:0] t;

   assign t = {rem_ff[10:0], sh_ff[63]};
   always_comb begin
      sh_in = sh_ff; rem_in = rem_ff; cnt_in = cnt_ff; run_in = run_ff; done = 1'b0;
      if (start) begin
         sh_in = dividend; rem_in = '0; cnt_in = '0; run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = (t >= {1'b0, modulus}) ? t - {1'b0, modulus} : t;
         sh_in = {sh_ff[62:0], 1'b0};
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            run_in = 1'b0; done = 1'b1;
         end
      end
   end
   assign remainder = rem_in[10:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         run_ff <= run_in; cnt_ff <= cnt_in;
      end
      sh_ff <= sh_in; rem_ff <= rem_in;
   end
endmodule

// ----- hdl/quadratic_probe_hash_table.sv -----
// Quadratic-probe hash table, top level. Uses qph_pkg, qph_hash, qph_mod.
// A request is hashed, reduced modulo the slot count and then probed slot by slot
// until rsp_valid; an insert into a half-full table is refused without hashing.
// Throughput: one transaction at a time; busy is high until rsp_valid.
// Reset: synchronous, active high; a clearing pass over all DEPTH entries then
// empties the used bits, busy high meanwhile. Results cannot be stalled.
module quadratic_probe_hash_table #(
   parameter int DEPTH = 1024,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_op,
   input  logic [63:0]            req_key,
   input  logic [VALUE_WIDTH-1:0] req_value_in,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_status,
   output logic [31:0]            rsp_value_out,
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic [10:0]            csr_wdata
);
   import qph_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = AW + 1;

   logic [TS_WIDTH-1:0] ts_ff;
   logic [KB_WIDTH-1:0] kb_ff;
   state_type state_ff, state_in;

   logic                   op_ff;
   logic [63:0]            key_ff, kmask;
   logic [VALUE_WIDTH-1:0] val_ff;
   logic [CW-1:0]          count_ff;
   logic [AW-1:0]          clr_ff;
   logic [11:0]            idx_ff, step_ff, i_ff;
   logic [11:0]            n;
   logic [3:0]             nb;
   logic [1:0]             st_ff;
   logic [31:0]            vout_ff;

   logic                   used_mem [DEPTH];
   logic [63:0]            key_mem [DEPTH];
   logic [VALUE_WIDTH-1:0] val_mem [DEPTH];
   logic                   used_rd;
   logic [63:0]            key_rd;
   logic [VALUE_WIDTH-1:0] val_rd;

   logic        h_start, h_done, m_start, m_done;
   logic [63:0] h_val;
   logic [10:0] m_rem;
   logic [12:0] sum;
   logic [11:0] idx_next;
   logic        wr_new, wr_val;

   always_comb begin
      if (ts_ff == '0) n = 12'd1;
      else if (32'(ts_ff) > DEPTH) n = 12'(DEPTH);
      else n = {1'b0, ts_ff};
      if (kb_ff == '0) nb = 4'd1;
      else if (kb_ff > 4'd8) nb = 4'd8;
      else nb = kb_ff;
   end
   assign kmask = ~64'd0 >> (7'd64 - {nb, 3'b000});

   qph_hash u_hash (.clock, .reset, .start(h_start), .key(key_ff), .nbytes(nb),
      .done(h_done), .hash(h_val));
   qph_mod u_mod (.clock, .reset, .start(m_start), .dividend(h_val),
      .modulus(n[10:0]), .done(m_done), .remainder(m_rem));

   // next probe: idx + 2i+1 mod n, both below n
   assign sum = {1'b0, idx_ff} + {1'b0, step_ff};
   always_comb begin
      if (sum >= {1'b0, n}) idx_next = 12'(sum - {1'b0, n});
      else idx_next = sum[11:0];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR:    if (clr_ff == AW'(DEPTH - 1)) state_in = S_IDLE;
         S_IDLE:     if (start) state_in = S_HASH_MUL;
         S_HASH_MUL: state_in = (op_ff == OP_INSERT && {count_ff, 1'b0} >= (CW+1)'(n))
                        ? S_DONE : S_HASH_ACC;
         S_HASH_ACC: if (h_done) state_in = S_MOD;
         S_MOD:      if (m_done) state_in = S_READ;
         S_ADDR:     state_in = S_READ;
         S_READ:     state_in = S_WAIT;
         S_WAIT:     state_in = S_CHECK;
         S_CHECK: begin
            if (!used_rd || (key_rd & kmask) == key_ff || i_ff + 12'd1 >= n)
               state_in = S_DONE;
            else state_in = S_ADDR;
         end
         S_DONE:     state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      busy = (state_ff != S_IDLE);
      h_start = (state_ff == S_HASH_MUL) && (state_in == S_HASH_ACC);
      m_start = (state_ff == S_HASH_ACC) && h_done;
      wr_new = (state_ff == S_CHECK) && (op_ff == OP_INSERT) && !used_rd;
      wr_val = (state_ff == S_CHECK) && (op_ff == OP_INSERT) &&
               (!used_rd || (key_rd & kmask) == key_ff);
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_CLEAR) used_mem[clr_ff] <= 1'b0;
      else if (wr_new) used_mem[AW'(idx_ff)] <= 1'b1;
      if (wr_new) key_mem[AW'(idx_ff)] <= key_ff;
      if (wr_val) val_mem[AW'(idx_ff)] <= val_ff;
      if (state_ff == S_READ) begin
         used_rd <= used_mem[AW'(idx_ff)];
         key_rd  <= key_mem[AW'(idx_ff)];
         val_rd  <= val_mem[AW'(idx_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; clr_ff <= '0; count_ff <= '0;
         ts_ff <= 11'd1021; kb_ff <= 4'd8; rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid <= 1'b0;
         if (state_ff == S_CLEAR) clr_ff <= clr_ff + AW'(1);
         if (csr_we) begin
            if (csr_index == REG_TABLE_SLOTS) ts_ff <= csr_wdata;
            else kb_ff <= csr_wdata[KB_WIDTH-1:0];
         end
         if (wr_new) count_ff <= count_ff + CW'(1);
         if (state_ff == S_DONE) rsp_valid <= 1'b1;
      end
      if (state_ff == S_IDLE && start) begin
         op_ff <= req_op; key_ff <= req_key & kmask; val_ff <= req_value_in;
      end
      if (state_ff == S_HASH_MUL) begin
         st_ff <= ST_FULL; vout_ff <= '0;
      end
      if (m_done) begin
         idx_ff <= {1'b0, m_rem};
         step_ff <= 12'd1; i_ff <= '0;
      end
      if (state_ff == S_CHECK) begin
         idx_ff <= idx_next;
         step_ff <= step_ff + 12'd2 >= n ? step_ff + 12'd2 - n : step_ff + 12'd2;
         i_ff <= i_ff + 12'd1;
         if ((key_rd & kmask) == key_ff && used_rd) begin
            st_ff <= ST_OK;
            vout_ff <= (op_ff == OP_LOOKUP) ? 32'(val_rd) : 32'd0;
         end else if (!used_rd) begin
            st_ff <= (op_ff == OP_INSERT) ? ST_OK : ST_NOT_FOUND;
         end else begin
            st_ff <= (op_ff == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
         end
      end
      rsp_status <= st_ff;
      rsp_value_out <= vout_ff;
   end

`ifndef SYNTHESIS
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$past(busy, 2) || $past(busy)) else $error("rsp order");
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double response");
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH)) else $error("count overflow");
`endif
endmodule

// ----- tb/qph_checker.sv -----
// Checker for the quadratic-probe hash table: tracks register writes and
// transactions, predicts each response and compares it. Depends on qph_pkg.
`timescale 1ns / 100ps
module qph_checker #(
   parameter int DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_op,
   input  logic [63:0] req_key,
   input  logic [31:0] req_value_in,
   input  logic        rsp_valid,
   input  logic [1:0]  rsp_status,
   input  logic [31:0] rsp_value_out,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [10:0] csr_wdata,
   output int          error_count,
   output int          pending_count,
   output int          accept_count
);
   import qph_pkg::*;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] value;
   } answer_type;

   logic        used_bits [DEPTH];
   logic [63:0] stored_keys [DEPTH];
   logic [31:0] stored_values [DEPTH];
   int unsigned stored_total;
   logic [10:0] slots_reg;
   logic [3:0]  bytes_reg;
   answer_type  answers [$];

   function automatic logic [63:0] fnv_hash(logic [63:0] key, int nbytes);
      logic [63:0] h;
      h = FNV_OFFSET;
      for (int i = 0; i < nbytes; i++) begin
         h = h ^ {56'd0, key[8*i +: 8]};
         h = h * FNV_PRIME;
      end
      return h;
   endfunction

   task automatic table_access(input logic op, input logic [63:0] key_raw,
                               input logic [31:0] data, output answer_type ans);
      int unsigned n, nb, idx, where;
      int found;
      logic [63:0] kmask, key, base;
      n = (slots_reg == 0) ? 1 : (slots_reg > DEPTH ? DEPTH : slots_reg);
      nb = (bytes_reg == 0) ? 1 : (bytes_reg > 8 ? 8 : bytes_reg);
      kmask = {64{1'b1}} >> (64 - 8 * nb);
      key = key_raw & kmask;
      ans.status = ST_NOT_FOUND;
      ans.value = '0;
      if (op == OP_INSERT && 2 * stored_total >= n) begin
         ans.status = ST_FULL;
         return;
      end
      base = fnv_hash(key, nb) % n;
      found = 2;
      where = 0;
      for (longint i = 0; i < n; i++) begin
         idx = (base + i * i) % n;
         where = idx;
         if (!used_bits[idx]) begin
            found = 1;
            break;
         end
         if ((stored_keys[idx] & kmask) == key) begin
            found = 0;
            break;
         end
      end
      if (op == OP_LOOKUP) begin
         if (found == 0) begin
            ans.status = ST_OK;
            ans.value = stored_values[where];
         end
      end else if (found == 2) begin
         ans.status = ST_FULL;
      end else begin
         if (found == 1) begin
            used_bits[where] = 1'b1;
            stored_keys[where] = key;
            stored_total++;
         end
         stored_values[where] = data;
         ans.status = ST_OK;
      end
   endtask

   always @(posedge clock) begin
      answer_type ans, want;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) used_bits[i] = 1'b0;
         stored_total = 0;
         slots_reg = 11'd1021;
         bytes_reg = 4'd8;
         answers.delete();
         error_count <= 0;
         accept_count <= 0;
      end else begin
         accept_count <= accept_count + (rsp_valid ? 1 : 0) + ((start && !busy) ? 1 : 0);
         if (rsp_valid) begin
            if (answers.size() == 0) begin
               error_count <= error_count + 1;
               if (error_count < 10)
                  $display("unexpected response status=%0d value=%h",
                           rsp_status, rsp_value_out);
            end else begin
               want = answers.pop_front();
               if (rsp_status !== want.status || rsp_value_out !== want.value) begin
                  error_count <= error_count + 1;
                  if (error_count < 10)
                     $display("mismatch: expected status=%0d value=%h, got %0d %h",
                              want.status, want.value, rsp_status, rsp_value_out);
               end
            end
         end
         if (start && !busy) begin
            table_access(req_op, req_key, req_value_in, ans);
            answers.push_back(ans);
         end
         if (csr_we) begin
            if (csr_index == REG_TABLE_SLOTS) slots_reg = csr_wdata;
            else bytes_reg = csr_wdata[3:0];
         end
      end
      pending_count <= answers.size();
   end
endmodule

// ----- tb/testbench.sv -----
// Top of the quadratic-probe hash table testbench: clock, reset, register
// phases and request stimulus. Depends on qph_pkg, qph_checker and the DUT.
`timescale 1ns / 100ps
module testbench;
   import qph_pkg::*;

   localparam int WATCHDOG = 200000;

   logic        clock, reset, start, busy, req_op;
   logic [63:0] req_key;
   logic [31:0] req_value_in;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_value_out;
   logic        csr_we, csr_index;
   logic [10:0] csr_wdata;
   int          error_count, pending_count, accept_count;
   int          idle_pct;
   int          stall_cycles;
   int          last_accepts;
   logic [63:0] key_pool [16];

   quadratic_probe_hash_table i_dut (.*);
   qph_checker i_checker (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      last_accepts <= accept_count;
      if (reset || accept_count != last_accepts || csr_we) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles > WATCHDOG) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send(input logic op, input logic [63:0] key, input logic [31:0] data);
      do @(negedge clock); while ($urandom_range(99) < idle_pct);
      start <= 1'b1;
      req_op <= op;
      req_key <= key;
      req_value_in <= data;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      start <= 1'b0;
   endtask

   task automatic drain();
      @(negedge clock);
      while (pending_count != 0 || busy) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [10:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [63:0] rand_key();
      return {$urandom, $urandom};
   endfunction

   task automatic random_phase(input int count);
      for (int i = 0; i < count; i++) begin
         logic [63:0] k;
         k = ($urandom_range(3) != 0) ? key_pool[$urandom_range(15)] : rand_key();
         send($urandom_range(1), k, $urandom);
      end
   endtask

   initial begin
      start = 0; req_op = 0; req_key = 0; req_value_in = 0;
      csr_we = 0; csr_index = 0; csr_wdata = 0;
      idle_pct = 0;
      reset = 1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;
      @(negedge clock);
      while (busy) @(negedge clock);
      foreach (key_pool[i]) key_pool[i] = rand_key();

      // directed: extremes, overwrite, lookup miss
      send(OP_LOOKUP, 64'd0, 32'd0);
      send(OP_INSERT, 64'd0, 32'hFFFFFFFF);
      send(OP_INSERT, {64{1'b1}}, 32'h0);
      send(OP_LOOKUP, 64'd0, 32'h1234);
      send(OP_LOOKUP, {64{1'b1}}, 32'h0);
      send(OP_INSERT, 64'd0, 32'hA5A5A5A5);
      send(OP_LOOKUP, 64'd0, 32'h0);
      send(OP_LOOKUP, 64'h5555AAAA5555AAAA, 32'h0);
      drain();
      // tiny table: half load refusal, short keys
      write_reg(REG_TABLE_SLOTS, 11'd3);
      write_reg(REG_KEY_BYTES, 4'd1);
      send(OP_INSERT, 64'hFF00, 32'd7);
      send(OP_LOOKUP, 64'h1200, 32'd0);
      send(OP_INSERT, 64'h0001, 32'd9);
      send(OP_INSERT, 64'h0000, 32'd9);
      drain();
      write_reg(REG_TABLE_SLOTS, 11'd0);
      send(OP_INSERT, 64'h7, 32'd1);
      send(OP_LOOKUP, 64'h0, 32'd0);
      drain();
      write_reg(REG_TABLE_SLOTS, 11'd2047);
      write_reg(REG_KEY_BYTES, 4'd0);
      send(OP_LOOKUP, 64'h0, 32'd0);
      send(OP_INSERT, 64'h33, 32'd5);
      drain();
      write_reg(REG_KEY_BYTES, 4'd15);
      send(OP_LOOKUP, {64{1'b1}}, 32'd0);
      drain();

      idle_pct = 35;
      write_reg(REG_TABLE_SLOTS, 11'd7);
      write_reg(REG_KEY_BYTES, 4'd2);
      random_phase(120);
      drain();
      idle_pct = 81;
      write_reg(REG_TABLE_SLOTS, 11'd61);
      write_reg(REG_KEY_BYTES, 4'd8);
      random_phase(200);
      drain();
      idle_pct = 0;
      write_reg(REG_TABLE_SLOTS, 11'd1021);
      write_reg(REG_KEY_BYTES, 4'd5);
      random_phase(150);
      drain();
      write_reg(REG_TABLE_SLOTS, 11'd1024);
      write_reg(REG_KEY_BYTES, 4'd3);
      random_phase(160);
      drain();
      repeat (50) @(negedge clock);

      if (error_count == 0 && pending_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
